### rtl/core/lss_pkg.sv
// Shared types and constants for the least-squares slope block.
// No dependencies; every other file in rtl/core imports this package.
package lss_pkg;

  localparam int MAX_SAMPLES     = 256;
  localparam int SAMPLE_BITS     = 24;
  localparam int SLOPE_FRAC_BITS = 16;

  // Fixed port field widths
  localparam int FIELD_W = 24;
  localparam int SLOPE_W = 32;

  // Accumulator and finalize widths
  localparam int COUNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam int SXY_W    = 56;
  localparam int SX_W     = 32;
  localparam int WIDE_W   = COUNT_W + SXY_W + 2;
  localparam int MAG_W    = 64;
  localparam int DIV_BITS = MAG_W + SLOPE_FRAC_BITS;
  localparam int DCNT_W   = $clog2(DIV_BITS);

  localparam logic [SLOPE_W-1:0] SAT_POS = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SAT_NEG = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIFF,
    ST_DIV_SETUP,
    ST_DIV,
    ST_RESULT
  } lss_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic mul_num;
    logic mul_den;
    logic diff;
    logic div_setup;
    logic div_step;
    logic load_out;
  } lss_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } lss_stat_t;

endpackage

### rtl/core/lss_in_if.sv
// Sample channel: valid/ready handshake carrying one (x, y, last) item.
// Depends on lss_pkg for the field width.
interface lss_in_if import lss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] x_value;
  logic [FIELD_W-1:0] y_value;
  logic               last;

  modport source (output valid, output x_value, output y_value, output last, input ready);
  modport sink   (input valid, input x_value, input y_value, input last, output ready);
endinterface

### rtl/core/lss_out_if.sv
// Result channel: valid/ready handshake carrying one slope item.
// Depends on lss_pkg for the field width.
interface lss_out_if import lss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOPE_W-1:0] slope;
  logic               zero_denominator;
  logic               too_many;

  modport source (output valid, output slope, output zero_denominator, output too_many,
                  input ready);
  modport sink   (input valid, input slope, input zero_denominator, input too_many,
                  output ready);
endinterface

### rtl/core/lss_ctrl.sv
// Sequencing FSM: accumulate, drain, finalize products, divide, emit.
// Depends on lss_pkg (state enum, command and status structs).
module lss_ctrl import lss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  lss_stat_t stat,
  output lss_cmd_t  cmd
);

  lss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_MUL_NUM;
      end
      ST_MUL_NUM:   state_nxt = ST_MUL_DEN;
      ST_MUL_DEN:   state_nxt = ST_DIFF;
      ST_DIFF:      state_nxt = ST_DIV_SETUP;
      ST_DIV_SETUP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_ACCUM;
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DRAIN:     ;
      ST_MUL_NUM:   cmd.mul_num   = 1'b1;
      ST_MUL_DEN:   cmd.mul_den   = 1'b1;
      ST_DIFF:      cmd.diff      = 1'b1;
      ST_DIV_SETUP: cmd.div_setup = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_RESULT: begin
        cmd.load_out = stat.out_free;
        cmd.clear    = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/lss_dp.sv
// Datapath: sample pipeline with running sums, finalize multipliers,
// restoring divider and output register. Depends on lss_pkg.
module lss_dp import lss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lss_cmd_t           cmd,
  output lss_stat_t          stat,
  input  logic [FIELD_W-1:0] x_value,
  input  logic [FIELD_W-1:0] y_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [SLOPE_W-1:0] slope,
  output logic               zero_denominator,
  output logic               too_many
);

  // Sample pipeline: capture, multiply, accumulate
  logic                          v1_r, v2_r;
  logic signed [SAMPLE_BITS-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [PROD_W-1:0]      pxy_r, pxx_r;

  logic signed [SXY_W-1:0] sum_xy_r, sum_xx_r;
  logic signed [SX_W-1:0]  sum_x_r, sum_y_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x1_r <= x_value[SAMPLE_BITS-1:0];
      y1_r <= y_value[SAMPLE_BITS-1:0];
    end
    pxy_r <= x1_r * y1_r;
    pxx_r <= x1_r * x1_r;
    x2_r  <= x1_r;
    y2_r  <= y1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_xy_r <= '0;
      sum_xx_r <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (v2_r) begin
      if (count_r < COUNT_W'(MAX_SAMPLES)) begin
        sum_xy_r <= sum_xy_r + SXY_W'(pxy_r);
        sum_xx_r <= sum_xx_r + SXY_W'(pxx_r);
        sum_x_r  <= sum_x_r + SX_W'(x2_r);
        sum_y_r  <= sum_y_r + SX_W'(y2_r);
        count_r  <= count_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Finalize: n*S2 and Sx*S1 share one multiplier pair, first for the numerator terms, then for the denominator terms
  logic signed [COUNT_W:0]       n_s;
  logic signed [SXY_W-1:0]       s2_sel;
  logic signed [SX_W-1:0]        s1_sel;
  logic signed [COUNT_W+SXY_W:0] pn;
  logic signed [2*SX_W-1:0]      ps;
  logic signed [WIDE_W-1:0]      a_r, b_r, num_r, den_r;

  assign n_s    = $signed({1'b0, count_r});
  assign s2_sel = cmd.mul_den ? sum_xx_r : sum_xy_r;
  assign s1_sel = cmd.mul_den ? sum_x_r : sum_y_r;
  assign pn     = n_s * s2_sel;
  assign ps     = sum_x_r * s1_sel;

  always_ff @(posedge clk) begin
    if (cmd.mul_num || cmd.mul_den) begin
      a_r <= WIDE_W'(pn);
      b_r <= WIDE_W'(ps);
    end
    if (cmd.mul_den) num_r <= a_r - b_r;
    if (cmd.diff)    den_r <= a_r - b_r;
  end

  // Restoring divider, one quotient bit per cycle; quotient shifts into dvd_r
  logic signed [WIDE_W-1:0] num_abs, den_abs;
  logic [MAG_W-1:0]         md_r, rem_r;
  logic [DIV_BITS-1:0]      dvd_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic                     neg_r, zero_r;
  logic [MAG_W:0]           trial;
  logic                     q_bit;

  assign num_abs = num_r[WIDE_W-1] ? -num_r : num_r;
  assign den_abs = den_r[WIDE_W-1] ? -den_r : den_r;
  assign trial   = {rem_r, dvd_r[DIV_BITS-1]};
  assign q_bit   = (trial >= {1'b0, md_r});

  always_ff @(posedge clk) begin
    if (cmd.div_setup) begin
      neg_r  <= num_r[WIDE_W-1] ^ den_r[WIDE_W-1];
      zero_r <= (den_r == '0);
      md_r   <= den_abs[MAG_W-1:0];
      dvd_r  <= DIV_BITS'(num_abs[MAG_W-1:0]) << SLOPE_FRAC_BITS;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? MAG_W'(trial - {1'b0, md_r}) : trial[MAG_W-1:0];
      dvd_r  <= {dvd_r[DIV_BITS-2:0], q_bit};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Saturate and sign the quotient; a zero denominator gives a zero slope
  logic [DIV_BITS-1:0] limit;
  logic [SLOPE_W-1:0]  q_mag, slope_nxt;

  assign limit     = DIV_BITS'(neg_r ? SAT_NEG : SAT_POS);
  assign q_mag     = (dvd_r > limit) ? limit[SLOPE_W-1:0] : dvd_r[SLOPE_W-1:0];
  assign slope_nxt = zero_r ? '0 : (neg_r ? -q_mag : q_mag);

  logic               out_valid_r;
  logic [SLOPE_W-1:0] slope_r;
  logic               zero_out_r, too_many_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slope_r    <= slope_nxt;
      zero_out_r <= zero_r;
      too_many_r <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign slope            = slope_r;
  assign zero_denominator = zero_out_r;
  assign too_many         = too_many_r;

  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.div_done  = (dcnt_r == DCNT_W'(DIV_BITS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

### rtl/core/least_squares_slope.sv
// Streaming least-squares slope. Each sample item (x, y) enters at one per clock while
// in_chan.ready is high and is added to the running sums through a three-stage pipe:
// capture, multiply, accumulate. After the item marked last, in_chan.ready drops while
// the pipe drains, the finalize steps form numerator and denominator and the divider
// runs; the restoring divider produces one quotient bit per clock of the Q16.16 slope.
// The result register is loaded once out_chan is free; a result still held on out_chan
// stretches the load step. Samples of the next set are taken while the result still
// waits on out_chan. Samples beyond MAX_SAMPLES are dropped and flagged in too_many.
// Depends on lss_pkg, lss_in_if, lss_out_if, lss_ctrl and lss_dp.
module least_squares_slope import lss_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  lss_in_if.sink    in_chan,
  lss_out_if.source out_chan
);

  lss_cmd_t  cmd;
  lss_stat_t stat;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .x_value          (in_chan.x_value),
    .y_value          (in_chan.y_value),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .slope            (out_chan.slope),
    .zero_denominator (out_chan.zero_denominator),
    .too_many         (out_chan.too_many)
  );

endmodule

### rtl/core/lss_chk.sv
// Port-level checks for least_squares_slope, bound to the top level.
// Depends on lss_pkg for field widths.
module lss_chk import lss_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SLOPE_W-1:0] slope,
  input logic               zero_denominator
);

  // Held result must not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slope))
    else $error("result item changed while stalled");

  // A last item closes the set: no sample taken in the following cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample accepted right after last item");

  // A fresh result appears exactly when sample intake reopens
  a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $rose(in_ready))
    else $error("result appeared outside set completion");

  // Zero denominator forces a zero slope
  a_zero_slope: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_denominator |-> slope == '0)
    else $error("nonzero slope with zero denominator");

endmodule

bind least_squares_slope lss_chk u_lss_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_last          (in_chan.last),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .slope            (out_chan.slope),
  .zero_denominator (out_chan.zero_denominator)
);
